// ----- rtl/core/wsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // Configuration register width
    localparam int CFG_W = 24;

    // Header bit fields and length codes
    localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
    localparam logic [7:0] HDR_OP_MASK  = 8'h0f;
    localparam logic [7:0] HDR_LEN_MASK = 8'h7f;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [3:0] OP_CONT      = 4'h0;
    localparam logic [3:0] OP_CLOSE     = 4'h8;

    // Extended length byte counts (minus one)
    localparam logic [2:0] EXT16_CNT = 3'd1;
    localparam logic [2:0] EXT64_CNT = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_PAY,
        PH_HALT
    } phase_t;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
    } result_t;

endpackage

// ----- rtl/core/wsdf_parser.sv -----
// ----------------------------------------------------------------------------
// wsdf_parser
// Frame parser state and single-pass per-byte decode, one byte per cycle while go is high.
// ----------------------------------------------------------------------------
module wsdf_parser #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,         // process in_byte this cycle
    input  logic [7:0]                in_byte,
    input  logic [wsdf_pkg::CFG_W-1:0] max_len,
    output logic                      res_valid,
    output wsdf_pkg::result_t         res
);

    localparam int LW = LENGTH_WIDTH;
    localparam logic [31:0] LEN_MASK32 = 32'((33'd1 << LW) - 33'd1);

    // State registers
    wsdf_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       ext_cnt_reg, ext_cnt_next;
    logic             fin_reg, fin_next;
    logic [3:0]       fop_reg, fop_next;
    logic             masked_reg, masked_next;
    logic [LW-1:0]    rem_reg, rem_next;
    logic             big_reg, big_next;      // extended length beyond LW bits
    logic [31:0]      key_reg, key_next;
    logic [1:0]       midx_reg, midx_next;
    logic             act_reg, act_next;
    logic [3:0]       mop_reg, mop_next;
    logic [LW-1:0]    mlen_reg, mlen_next;
    logic             skip_reg, skip_next;

    // Effective limit: register capped at the length range
    logic [31:0]   cfg32;
    logic [31:0]   limit32;
    logic [LW-1:0] limit;

    assign cfg32   = {{(32 - wsdf_pkg::CFG_W){1'b0}}, max_len};
    assign limit32 = (cfg32 > LEN_MASK32) ? LEN_MASK32 : cfg32;
    assign limit   = limit32[LW-1:0];

    // Byte decode
    logic [6:0]    len7;
    logic [LW+7:0] ext_shift;
    logic [LW-1:0] known_val;
    logic          known_big;
    logic [LW:0]   len_sum;
    logic          over;
    logic          ctl;
    logic [LW-1:0] rem_dec;
    logic          pay_end;
    logic [7:0]    key_byte;

    assign len7      = in_byte[6:0] & wsdf_pkg::HDR_LEN_MASK[6:0];
    assign ext_shift = {rem_reg, in_byte};
    assign known_val = (phase_reg == wsdf_pkg::PH_HDR1) ? LW'(len7) : ext_shift[LW-1:0];
    assign known_big = (phase_reg == wsdf_pkg::PH_EXT) &&
                       (big_reg || (ext_shift[LW+7:LW] != 8'd0));
    assign len_sum   = {1'b0, mlen_reg} + {1'b0, known_val};
    assign over      = known_big || (known_val > limit) || (len_sum > {1'b0, limit});
    assign ctl       = fop_reg >= wsdf_pkg::OP_CLOSE;
    assign rem_dec   = rem_reg - LW'(1);
    assign pay_end   = (rem_dec == '0);

    always_comb
    begin
        case (midx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Events set by next-state logic, some also used by output logic
    logic          known;       // frame length complete this byte
    logic          sp_fire;     // header done, payload may start
    logic [LW-1:0] sp_len;
    logic          empty_ev;    // empty message end
    logic [3:0]    empty_op;

    // Next-state logic
    always_comb
    begin
        phase_next  = phase_reg;
        ext_cnt_next = ext_cnt_reg;
        fin_next    = fin_reg;
        fop_next    = fop_reg;
        masked_next = masked_reg;
        rem_next    = rem_reg;
        big_next    = big_reg;
        key_next    = key_reg;
        midx_next   = midx_reg;
        act_next    = act_reg;
        mop_next    = mop_reg;
        mlen_next   = mlen_reg;
        skip_next   = skip_reg;
        known       = 1'b0;
        sp_fire     = 1'b0;
        sp_len      = rem_reg;
        empty_ev    = 1'b0;
        empty_op    = fop_reg;

        if (go)
        begin
            unique case (phase_reg)
                wsdf_pkg::PH_HDR0:
                begin
                    fin_next   = (in_byte & wsdf_pkg::HDR_FIN_BIT) != 8'd0;
                    fop_next   = in_byte[3:0] & wsdf_pkg::HDR_OP_MASK[3:0];
                    phase_next = wsdf_pkg::PH_HDR1;
                    if (act_reg && (fop_next != wsdf_pkg::OP_CONT))
                    begin
                        act_next = 1'b0;
                    end
                end
                wsdf_pkg::PH_HDR1:
                begin
                    masked_next = in_byte[7];
                    rem_next    = '0;
                    big_next    = 1'b0;
                    if (len7 == wsdf_pkg::LEN_EXT16)
                    begin
                        ext_cnt_next = wsdf_pkg::EXT16_CNT;
                        phase_next   = wsdf_pkg::PH_EXT;
                    end
                    else if (len7 == wsdf_pkg::LEN_EXT64)
                    begin
                        ext_cnt_next = wsdf_pkg::EXT64_CNT;
                        phase_next   = wsdf_pkg::PH_EXT;
                    end
                    else
                    begin
                        known = 1'b1;
                    end
                end
                wsdf_pkg::PH_EXT:
                begin
                    rem_next = ext_shift[LW-1:0];
                    big_next = known_big;
                    if (ext_cnt_reg == 3'd0)
                    begin
                        known = 1'b1;
                    end
                    else
                    begin
                        ext_cnt_next = ext_cnt_reg - 3'd1;
                    end
                end
                wsdf_pkg::PH_MASK:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    if (midx_reg == 2'd3)
                    begin
                        sp_fire = 1'b1;
                        sp_len  = rem_reg;
                    end
                    else
                    begin
                        midx_next = midx_reg + 2'd1;
                    end
                end
                wsdf_pkg::PH_PAY:
                begin
                    midx_next = midx_reg + 2'd1;
                    rem_next  = rem_dec;
                    if (pay_end)
                    begin
                        phase_next = wsdf_pkg::PH_HDR0;
                    end
                    if (skip_reg)
                    begin
                        if (pay_end)
                        begin
                            skip_next = 1'b0;
                        end
                    end
                    else if (pay_end && fin_reg && !ctl)
                    begin
                        act_next  = 1'b0;
                        mlen_next = '0;
                    end
                end
                default:
                begin
                    phase_next = wsdf_pkg::PH_HALT;
                end
            endcase

            // Frame length known: limit check and message bookkeeping
            if (known)
            begin
                rem_next = known_val;
                if (over)
                begin
                    phase_next = wsdf_pkg::PH_HALT;
                end
                else
                begin
                    skip_next = 1'b0;
                    if (ctl)
                    begin
                        act_next  = 1'b0;
                        mlen_next = '0;
                    end
                    else if (fop_reg != wsdf_pkg::OP_CONT)
                    begin
                        act_next  = 1'b1;
                        mop_next  = fop_reg;
                        mlen_next = known_val;
                    end
                    else if (act_reg)
                    begin
                        mlen_next = len_sum[LW-1:0];
                    end
                    else
                    begin
                        skip_next = 1'b1;
                    end
                    key_next = '0;
                    if (masked_next)
                    begin
                        phase_next = wsdf_pkg::PH_MASK;
                        midx_next  = 2'd0;
                    end
                    else
                    begin
                        sp_fire = 1'b1;
                        sp_len  = known_val;
                    end
                end
            end

            // Start payload or close an empty frame
            if (sp_fire)
            begin
                midx_next = 2'd0;
                if (sp_len != '0)
                begin
                    phase_next = wsdf_pkg::PH_PAY;
                end
                else
                begin
                    phase_next = wsdf_pkg::PH_HDR0;
                    if (skip_next)
                    begin
                        skip_next = 1'b0;
                    end
                    else if (ctl)
                    begin
                        empty_ev = 1'b1;
                        empty_op = fop_reg;
                    end
                    else if (fin_reg)
                    begin
                        empty_ev  = 1'b1;
                        empty_op  = mop_next;
                        act_next  = 1'b0;
                        mlen_next = '0;
                    end
                end
            end
        end
    end

    // Output logic
    always_comb
    begin
        res_valid  = 1'b0;
        res.kind   = wsdf_pkg::KIND_PAYLOAD;
        res.data   = 8'd0;
        res.opcode = fop_reg;
        res.last   = 1'b0;
        if (go)
        begin
            if (phase_reg == wsdf_pkg::PH_HDR0)
            begin
                if (act_reg && ((in_byte[3:0] & wsdf_pkg::HDR_OP_MASK[3:0]) != wsdf_pkg::OP_CONT))
                begin
                    res_valid  = 1'b1;
                    res.kind   = wsdf_pkg::KIND_DROP;
                    res.opcode = mop_reg;
                end
            end
            else if (known && over)
            begin
                res_valid  = 1'b1;
                res.kind   = wsdf_pkg::KIND_ERROR;
                res.opcode = fop_reg;
            end
            else if (empty_ev)
            begin
                res_valid  = 1'b1;
                res.kind   = wsdf_pkg::KIND_EMPTY;
                res.opcode = empty_op;
                res.last   = 1'b1;
            end
            else if ((phase_reg == wsdf_pkg::PH_PAY) && !skip_reg)
            begin
                res_valid  = 1'b1;
                res.kind   = wsdf_pkg::KIND_PAYLOAD;
                res.data   = in_byte ^ key_byte;
                res.opcode = ctl ? fop_reg : mop_reg;
                res.last   = pay_end && (ctl || fin_reg);
            end
        end
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= wsdf_pkg::PH_HDR0;
            ext_cnt_reg <= 3'd0;
            fin_reg     <= 1'b0;
            fop_reg     <= 4'd0;
            masked_reg  <= 1'b0;
            rem_reg     <= '0;
            big_reg     <= 1'b0;
            key_reg     <= 32'd0;
            midx_reg    <= 2'd0;
            act_reg     <= 1'b0;
            mop_reg     <= 4'd0;
            mlen_reg    <= '0;
            skip_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            ext_cnt_reg <= ext_cnt_next;
            fin_reg     <= fin_next;
            fop_reg     <= fop_next;
            masked_reg  <= masked_next;
            rem_reg     <= rem_next;
            big_reg     <= big_next;
            key_reg     <= key_next;
            midx_reg    <= midx_next;
            act_reg     <= act_next;
            mop_reg     <= mop_next;
            mlen_reg    <= mlen_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

// ----- rtl/core/wsdf_out_buf.sv -----
// ----------------------------------------------------------------------------
// wsdf_out_buf
// Two-entry result buffer; decouples the parser from output backpressure.
// ----------------------------------------------------------------------------
module wsdf_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsdf_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output wsdf_pkg::result_t out_data
);

    wsdf_pkg::result_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;
    assign out_data  = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Byte-stream WebSocket frame parser with unmasking and message reassembly.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and sustains one byte per clock cycle
// while the output buffer has room. A byte lands in an input register, is
// decoded in a single pass against the frame state once the output buffer
// has room, and its result (if any) is written into a two-entry output
// buffer that presents it on the master side. The output buffer sets the
// only stall: the slave side keeps taking bytes while one result waits and
// stops only while two results wait and a byte is held in the input register.
// Results are payload bytes (tuser 0), empty message ends (1), partial
// message drops (2) and an oversize error (3); after an error the block
// consumes bytes without results until reset. max_message_len may only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration
    input  logic                       cfg_we,
    input  logic [wsdf_pkg::CFG_W-1:0] cfg_wdata,   // max_message_len
    // Received bytes
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
    // Results
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // [7:0] out_byte, [11:8] out_opcode
    output logic [1:0]                 m_axis_tuser,  // [1:0] out_kind
    output logic                       m_axis_tlast   // out_last
);

    // Configuration register
    logic [wsdf_pkg::CFG_W-1:0] max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= wsdf_pkg::CFG_W'(65536);
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       buf_full;
    logic       go;

    assign go            = in_valid_reg && !buf_full;
    assign s_axis_tready = !in_valid_reg || !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Parser
    logic              res_valid;
    wsdf_pkg::result_t res;

    wsdf_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .in_byte   (in_byte_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result buffer
    wsdf_pkg::result_t out_res;

    wsdf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {4'd0, out_res.opcode, out_res.data};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

    // Assertions
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg)
        else $error("input stalled with no pending byte");

    a_marker_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == wsdf_pkg::KIND_ERROR ||
                          m_axis_tuser == wsdf_pkg::KIND_DROP) |-> !m_axis_tlast)
        else $error("drop or error marker flagged as last");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == wsdf_pkg::KIND_EMPTY |->
            m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
        else $error("empty end without last flag or with data");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        buf_full |-> !res_valid)
        else $error("result produced while buffer full");

endmodule
